>>> hw/rtl/btl_pkg.sv
// shared types and constants for the bin tape loader
package btl_pkg;

    // frame classes handed from the front to the back
    typedef enum logic [2:0] {
        OP_NOP,
        OP_END,
        OP_FIELD,
        OP_TRAILER,
        OP_BAD,
        OP_FRAME
    } op_t;

    // word assembly phase
    typedef enum logic [2:0] {
        PH_HI_ADDR,
        PH_LO_ADDR,
        PH_HI_DATA,
        PH_LO_DATA,
        PH_WORD,
        PH_NONE
    } phase_t;

    // load status codes
    typedef enum logic [2:0] {
        ST_RUNNING,
        ST_LOADED,
        ST_BAD_FRAME,
        ST_NO_MARK,
        ST_CHECKSUM,
        ST_EARLY_END
    } status_t;

    // classified frame: op plus the low seven frame bits
    typedef struct packed {
        op_t        op;
        logic [6:0] data;
    } cmd_t;

    localparam logic [7:0] RUBOUT_CODE = 8'o377;
    localparam logic [7:0] LEADER_CODE = 8'o200;

endpackage

>>> hw/rtl/btl_if.sv
// channel interfaces for tape frames and load results
interface btl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] tape_byte;
    logic       tape_end;

    modport source (output valid, tape_byte, tape_end, input ready);
    modport sink (input valid, tape_byte, tape_end, output ready);
endinterface

interface btl_out_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [14:0] write_address;
    logic [11:0] write_data;
    logic        start_given;
    logic [14:0] start_address;
    logic [2:0]  status;

    modport source (output valid, write_valid, write_address, write_data, start_given,
                    start_address, status, input ready);
    modport sink (input valid, write_valid, write_address, write_data, start_given,
                  start_address, status, output ready);
endinterface

>>> hw/rtl/btl_front.sv
// front end: accepts tape frames, tracks rubout and leader, classifies frames
module btl_front (
    input  logic            clk,
    input  logic            rst_n,
    btl_in_if.sink          tape_in,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output btl_pkg::cmd_t   cmd
);
    import btl_pkg::*;

    logic rubout_reg, rubout_next;
    logic leader_reg, leader_next;
    logic accept;

    assign tape_in.ready = cmd_ready;
    assign cmd_valid     = tape_in.valid;
    assign accept        = tape_in.valid && cmd_ready;

    // frame classification
    always_comb
    begin
        rubout_next = rubout_reg;
        leader_next = leader_reg;
        cmd.data    = tape_in.tape_byte[6:0];
        if (tape_in.tape_end)
        begin
            cmd.op = OP_END;
        end
        else if (tape_in.tape_byte == RUBOUT_CODE)
        begin
            cmd.op      = OP_NOP;
            rubout_next = !rubout_reg;
        end
        else if (rubout_reg)
        begin
            cmd.op = OP_NOP;
        end
        else if (tape_in.tape_byte[7:6] == 2'b11)
        begin
            cmd.op = OP_FIELD;
        end
        else if (tape_in.tape_byte == LEADER_CODE)
        begin
            cmd.op = leader_reg ? OP_NOP : OP_TRAILER;
        end
        else
        begin
            leader_next = 1'b0;
            cmd.op      = tape_in.tape_byte[7] ? OP_BAD : OP_FRAME;
        end
    end

    // tape mode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rubout_reg <= 1'b0;
            leader_reg <= 1'b1;
        end
        else if (accept)
        begin
            rubout_reg <= rubout_next;
            leader_reg <= leader_next;
        end
    end

endmodule

>>> hw/rtl/btl_queue.sv
// two-entry queue between the front and the back
module btl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  btl_pkg::cmd_t   push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output btl_pkg::cmd_t   pop_data
);
    import btl_pkg::*;

    cmd_t       store_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> hw/rtl/btl_back.sv
// back end: word assembly, checksum, memory writes and status, with result register
module btl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  btl_pkg::cmd_t   cmd,
    btl_out_if.source       load_out
);
    import btl_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [11:0] addr_reg, addr_next;
    logic [11:0] data_reg, data_next;
    logic [11:0] sum_reg, sum_next;
    logic [2:0]  field_reg, field_next;
    logic [14:0] start_reg, start_next;
    logic        pending_reg, pending_next;
    status_t     status_reg, status_next;
    logic        wv_next;
    logic [14:0] wa_next;
    logic [11:0] wd_next;
    logic [11:0] check;
    logic [5:0]  ch;
    phase_t      ph;

    logic        out_valid_reg;
    logic        wv_reg;
    logic [14:0] wa_reg;
    logic [11:0] wd_reg;
    logic        given_reg;
    logic [14:0] saddr_reg;
    logic [2:0]  ostat_reg;
    logic        take;

    assign cmd_ready = !out_valid_reg || load_out.ready;
    assign take      = cmd_valid && cmd_ready;

    // checksum less both halves of the last word
    assign check = sum_reg - {6'd0, data_reg[5:0]} - {6'd0, data_reg[11:6]};

    // execute one classified frame
    always_comb
    begin
        phase_next   = phase_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        sum_next     = sum_reg;
        field_next   = field_reg;
        start_next   = start_reg;
        pending_next = pending_reg;
        status_next  = status_reg;
        wv_next      = 1'b0;
        wa_next      = '0;
        wd_next      = '0;
        ch           = cmd.data[5:0];
        ph           = phase_reg;
        if (status_reg == ST_RUNNING)
        begin
            case (cmd.op)
                OP_END:     status_next = ST_EARLY_END;
                OP_FIELD:   field_next  = cmd.data[5:3];
                OP_TRAILER: status_next = (check == data_reg) ? ST_LOADED : ST_CHECKSUM;
                OP_BAD:     status_next = ST_BAD_FRAME;
                OP_FRAME:
                begin
                    sum_next = sum_reg + {5'd0, cmd.data};
                    // emit the finished word
                    if (phase_reg == PH_WORD)
                    begin
                        wv_next      = 1'b1;
                        wa_next      = {field_reg, addr_reg};
                        wd_next      = data_reg;
                        addr_next    = addr_reg + 12'd1;
                        pending_next = 1'b0;
                        ph           = PH_HI_DATA;
                    end
                    // address mark restarts the address
                    if (cmd.data[6])
                    begin
                        ph = PH_HI_ADDR;
                    end
                    unique case (ph)
                        PH_HI_ADDR:
                        begin
                            addr_next  = {ch, 6'd0};
                            phase_next = PH_LO_ADDR;
                        end
                        PH_LO_ADDR:
                        begin
                            addr_next    = {addr_reg[11:6], ch};
                            start_next   = {field_reg, addr_reg[11:6], ch};
                            pending_next = 1'b1;
                            phase_next   = PH_HI_DATA;
                        end
                        PH_HI_DATA:
                        begin
                            data_next  = {ch, 6'd0};
                            phase_next = PH_LO_DATA;
                        end
                        PH_LO_DATA:
                        begin
                            data_next  = {data_reg[11:6], ch};
                            phase_next = PH_WORD;
                        end
                        default:
                        begin
                            status_next = ST_NO_MARK;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // loader state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_NONE;
            addr_reg    <= '0;
            data_reg    <= '0;
            sum_reg     <= '0;
            field_reg   <= '0;
            start_reg   <= '0;
            pending_reg <= 1'b0;
            status_reg  <= ST_RUNNING;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            addr_reg    <= addr_next;
            data_reg    <= data_next;
            sum_reg     <= sum_next;
            field_reg   <= field_next;
            start_reg   <= start_next;
            pending_reg <= pending_next;
            status_reg  <= status_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            out_valid_reg <= cmd_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            wv_reg    <= wv_next;
            wa_reg    <= wa_next;
            wd_reg    <= wd_next;
            given_reg <= pending_next;
            saddr_reg <= start_next;
            ostat_reg <= status_next;
        end
    end

    assign load_out.valid         = out_valid_reg;
    assign load_out.write_valid   = wv_reg;
    assign load_out.write_address = wa_reg;
    assign load_out.write_data    = wd_reg;
    assign load_out.start_given   = given_reg;
    assign load_out.start_address = saddr_reg;
    assign load_out.status        = ostat_reg;

endmodule

>>> hw/rtl/bin_tape_loader_core.sv
// Loader for BIN-format paper tape: one frame per transaction in, one load result per
// transaction out. A frame is taken every clock cycle as long as the result side keeps
// up; the front classifies it in the cycle it is taken, a two-entry queue holds it, and
// the back, once it pops it from the queue, updates the loader state and fills the
// result register. The frame rate is set by the back's one state update per frame (a
// 12-bit add, the checksum subtract and compare). A result carries a memory write when
// a data word completes, the pending start address and the load status; once status
// leaves running it holds until reset.
module bin_tape_loader_core (
    input  logic      clk,
    input  logic      rst_n,
    btl_in_if.sink    tape_in,
    btl_out_if.source load_out
);
    import btl_pkg::*;

    logic front_valid, front_ready;
    cmd_t front_cmd;
    logic back_valid, back_ready;
    cmd_t back_cmd;

    // frame classification
    btl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tape_in   (tape_in),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // decoupling queue
    btl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    // loader execution
    btl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .load_out  (load_out)
    );

endmodule
